FILE: src/mrfb_pkg.sv
`timescale 1ns / 1ps
package mrfb_pkg;

  localparam int DATA_W     = 64;
  localparam int CMD_W      = 7;
  localparam int ADDR_W     = 34;
  localparam int CUBE_W     = 3;
  localparam int LEN_W      = 5;
  localparam int TAG_W      = 11;
  localparam int BSS_W      = 2;
  localparam int LINK_COUNT = 4;
  localparam int LINK_W     = $clog2(LINK_COUNT);

  // lowest address bit of the link field at the smallest block size
  localparam int LINK_ADDR_BASE = 8;

  localparam logic [2:0] HDR_RSVD  = 3'b111;
  localparam logic [3:0] TAIL_RSVD = 4'b1111;
  localparam int TAIL_RSVD_LSB = 22;
  localparam int TAIL_LINK_LSB = 26;

  typedef enum logic {
    OP_REQUEST = 1'b0,
    OP_DATA    = 1'b1
  } op_t;

  // request command codes
  localparam logic [CMD_W-1:0] CMD_WR16       = 7'h08;
  localparam logic [CMD_W-1:0] CMD_WR128      = 7'h0F;
  localparam logic [CMD_W-1:0] CMD_MD_WR      = 7'h10;
  localparam logic [CMD_W-1:0] CMD_BWR        = 7'h11;
  localparam logic [CMD_W-1:0] CMD_TWO_ADD8   = 7'h12;
  localparam logic [CMD_W-1:0] CMD_ADD16      = 7'h13;
  localparam logic [CMD_W-1:0] CMD_P_WR16     = 7'h18;
  localparam logic [CMD_W-1:0] CMD_P_WR128    = 7'h1F;
  localparam logic [CMD_W-1:0] CMD_P_BWR      = 7'h21;
  localparam logic [CMD_W-1:0] CMD_P_TWO_ADD8 = 7'h22;
  localparam logic [CMD_W-1:0] CMD_P_ADD16    = 7'h23;
  localparam logic [CMD_W-1:0] CMD_MD_RD      = 7'h28;
  localparam logic [CMD_W-1:0] CMD_RD16       = 7'h30;
  localparam logic [CMD_W-1:0] CMD_RD128      = 7'h37;
  localparam logic [CMD_W-1:0] CMD_BOOL_FIRST = 7'h40;
  localparam logic [CMD_W-1:0] CMD_BOOL_LAST  = 7'h44;
  localparam logic [CMD_W-1:0] CMD_WR256      = 7'h4F;
  localparam logic [CMD_W-1:0] CMD_INC8       = 7'h50;
  localparam logic [CMD_W-1:0] CMD_BWR8R      = 7'h51;
  localparam logic [CMD_W-1:0] CMD_TWO_ADDS8R = 7'h52;
  localparam logic [CMD_W-1:0] CMD_ADDS16R    = 7'h53;
  localparam logic [CMD_W-1:0] CMD_P_INC8     = 7'h54;
  localparam logic [CMD_W-1:0] CMD_P_WR256    = 7'h5F;
  localparam logic [CMD_W-1:0] CMD_CAS_FIRST  = 7'h60;
  localparam logic [CMD_W-1:0] CMD_CAS_LAST   = 7'h63;
  localparam logic [CMD_W-1:0] CMD_CASEQ8     = 7'h64;
  localparam logic [CMD_W-1:0] CMD_CASZERO16  = 7'h65;
  localparam logic [CMD_W-1:0] CMD_EQ16       = 7'h68;
  localparam logic [CMD_W-1:0] CMD_EQ8        = 7'h69;
  localparam logic [CMD_W-1:0] CMD_SWAP16     = 7'h6A;
  localparam logic [CMD_W-1:0] CMD_RD256      = 7'h77;

  // one queue entry: a flit plus an optional tail flit behind it
  typedef struct packed {
    logic [DATA_W-1:0] lo0;
    logic [DATA_W-1:0] hi0;
    logic              last0;
    logic              has_tail;
    logic [DATA_W-1:0] tail_lo;
    logic [LINK_W-1:0] link;
    logic [TAG_W-1:0]  tag;
  } flit_entry_t;

  function automatic logic [LEN_W-1:0] packet_length(input logic [CMD_W-1:0] cmd);
    logic [LEN_W-1:0] n;
    unique case (cmd) inside
      [CMD_WR16:CMD_WR128],
      [CMD_P_WR16:CMD_P_WR128]:          n = {2'b00, cmd[2:0]} + LEN_W'(2);
      [CMD_RD16:CMD_RD128],
      CMD_RD256, CMD_MD_RD,
      CMD_INC8, CMD_P_INC8:              n = LEN_W'(1);
      CMD_WR256, CMD_P_WR256:            n = LEN_W'(17);
      CMD_MD_WR, CMD_BWR, CMD_TWO_ADD8, CMD_ADD16,
      CMD_P_BWR, CMD_P_TWO_ADD8, CMD_P_ADD16,
      CMD_BWR8R, CMD_TWO_ADDS8R, CMD_ADDS16R,
      [CMD_BOOL_FIRST:CMD_BOOL_LAST],
      [CMD_CAS_FIRST:CMD_CAS_LAST],
      CMD_CASEQ8, CMD_CASZERO16, CMD_EQ16, CMD_EQ8,
      CMD_SWAP16:                        n = LEN_W'(2);
      default:                           n = '0;
    endcase
    return n;
  endfunction

  function automatic logic [DATA_W-1:0] make_tail(input logic [LINK_W-1:0] link);
    logic [DATA_W-1:0] t;
    t = '0;
    t[TAIL_RSVD_LSB +: 4]      = TAIL_RSVD;
    t[TAIL_LINK_LSB +: LINK_W] = link;
    return t;
  endfunction

endpackage

FILE: src/memory_request_flit_builder.sv
`timescale 1ns / 1ps
// Request packet framer: turns request beats into 128-bit flits (two 64-bit
// halves per beat on each side). A request beat (operation 0) carries the
// command, address, cube id and first data beat; data beats (operation 1)
// carry the rest. The command sets the packet length in flits; unknown
// commands, or lengths above MAX_FLITS, give no flits and take no tag. A new
// request drops any unfinished packet, and a data beat outside a packet is
// dropped. The link comes from address bits picked by cfg_wdata (block size
// select), which the user must write only while the block is idle; the block
// itself does not enforce this. One input beat is taken per cycle while the
// front-to-back queue (QUEUE_DEPTH entries) has room. Each beat yields zero,
// one or two flits; the output register sends one flit per cycle while
// out_ready is high, so beats that finish a packet (and length-2 requests)
// send two flits and the output port sets the sustained rate. A flit passes
// through the queue and then the output register before it is shown.
module memory_request_flit_builder #(
  parameter int TAG_BITS    = 11,
  parameter int MAX_FLITS   = 17,
  parameter int QUEUE_DEPTH = 4
) (
  input  logic                         clk,
  input  logic                         rst_n,
  // configuration
  input  logic                         cfg_we,
  input  logic [mrfb_pkg::BSS_W-1:0]   cfg_wdata,
  // input beats
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic                         in_operation,
  input  logic [mrfb_pkg::CMD_W-1:0]   in_command,
  input  logic [mrfb_pkg::ADDR_W-1:0]  in_address,
  input  logic [mrfb_pkg::CUBE_W-1:0]  in_cube_id,
  input  logic [mrfb_pkg::DATA_W-1:0]  in_data_low,
  input  logic [mrfb_pkg::DATA_W-1:0]  in_data_high,
  // flit beats
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [mrfb_pkg::DATA_W-1:0]  out_flit_low,
  output logic [mrfb_pkg::DATA_W-1:0]  out_flit_high,
  output logic [mrfb_pkg::LINK_W-1:0]  out_link,
  output logic                         out_last,
  output logic [TAG_BITS-1:0]          out_tag
);
  import mrfb_pkg::*;

  // front -> queue
  logic        push_valid, push_ready;
  flit_entry_t push_data;
  // queue -> back
  logic        head_valid, head_pop;
  flit_entry_t head;

  // front: decode, header build, tag and packet tracking
  mrfb_front #(
    .TAG_BITS  (TAG_BITS),
    .MAX_FLITS (MAX_FLITS)
  ) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_operation (in_operation),
    .in_command   (in_command),
    .in_address   (in_address),
    .in_cube_id   (in_cube_id),
    .in_data_low  (in_data_low),
    .in_data_high (in_data_high),
    .push_valid   (push_valid),
    .push_ready   (push_ready),
    .push_data    (push_data)
  );

  // decoupling queue, one entry per beat that produces flits
  mrfb_queue #(
    .WIDTH ($bits(flit_entry_t)),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (head_valid),
    .pop_ready  (head_pop),
    .pop_data   (head)
  );

  // back: serializes each entry into one or two flits
  mrfb_back #(
    .TAG_BITS (TAG_BITS)
  ) u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .head_valid    (head_valid),
    .head_pop      (head_pop),
    .head          (head),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_flit_low  (out_flit_low),
    .out_flit_high (out_flit_high),
    .out_link      (out_link),
    .out_last      (out_last),
    .out_tag       (out_tag)
  );

endmodule

FILE: src/mrfb_front.sv
`timescale 1ns / 1ps
module mrfb_front #(
  parameter int TAG_BITS  = 11,
  parameter int MAX_FLITS = 17
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_we,
  input  logic [mrfb_pkg::BSS_W-1:0]   cfg_wdata,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic                         in_operation,
  input  logic [mrfb_pkg::CMD_W-1:0]   in_command,
  input  logic [mrfb_pkg::ADDR_W-1:0]  in_address,
  input  logic [mrfb_pkg::CUBE_W-1:0]  in_cube_id,
  input  logic [mrfb_pkg::DATA_W-1:0]  in_data_low,
  input  logic [mrfb_pkg::DATA_W-1:0]  in_data_high,
  output logic                         push_valid,
  input  logic                         push_ready,
  output mrfb_pkg::flit_entry_t        push_data
);
  import mrfb_pkg::*;

  logic [BSS_W-1:0]    bss_r;
  logic [TAG_BITS-1:0] tag_cnt_r, tag_cnt_nxt;
  logic [DATA_W-1:0]   held_r, held_nxt;
  logic [LEN_W-1:0]    rem_r, rem_nxt;
  logic [LINK_W-1:0]   pkt_link_r, pkt_link_nxt;
  logic [TAG_BITS-1:0] pkt_tag_r, pkt_tag_nxt;

  logic              accept;
  logic [LEN_W-1:0]  len_raw, len;
  logic [LEN_W-1:0]  rem_dec;
  logic [ADDR_W-1:0] addr_sh;
  logic [LINK_W-1:0] new_link;
  logic [DATA_W-1:0] header;

  assign in_ready = push_ready;
  assign accept   = in_valid && push_ready;

  assign len_raw  = packet_length(in_command);
  assign len      = (len_raw > LEN_W'(MAX_FLITS)) ? '0 : len_raw;
  assign addr_sh  = in_address >> (LINK_ADDR_BASE + int'(bss_r));
  assign new_link = addr_sh[LINK_W-1:0];
  assign rem_dec  = rem_r - LEN_W'(1);
  assign header   = {in_cube_id, HDR_RSVD, in_address, 1'b0,
                     TAG_W'(tag_cnt_r), len, in_command};

  always_comb begin
    tag_cnt_nxt  = tag_cnt_r;
    held_nxt     = held_r;
    rem_nxt      = rem_r;
    pkt_link_nxt = pkt_link_r;
    pkt_tag_nxt  = pkt_tag_r;
    push_valid   = 1'b0;
    push_data    = '0;
    if (accept) begin
      if (in_operation == OP_REQUEST) begin
        rem_nxt = '0;
        if (len != '0) begin
          pkt_link_nxt   = new_link;
          pkt_tag_nxt    = tag_cnt_r;
          tag_cnt_nxt    = tag_cnt_r + 1'b1;
          push_valid     = 1'b1;
          push_data.link = new_link;
          push_data.tag  = TAG_W'(tag_cnt_r);
          push_data.lo0  = header;
          if (len == LEN_W'(1)) begin
            // header and tail share the only flit
            push_data.hi0   = make_tail(new_link);
            push_data.last0 = 1'b1;
          end else begin
            push_data.hi0      = in_data_low;
            push_data.tail_lo  = in_data_high;
            push_data.has_tail = (len == LEN_W'(2));
            held_nxt           = in_data_high;
            rem_nxt            = (len == LEN_W'(2)) ? '0 : len - LEN_W'(1);
          end
        end
      end else if (rem_r != '0) begin
        push_valid        = 1'b1;
        push_data.link    = pkt_link_r;
        push_data.tag     = TAG_W'(pkt_tag_r);
        push_data.lo0     = held_r;
        push_data.hi0     = in_data_low;
        push_data.tail_lo = in_data_high;
        held_nxt          = in_data_high;
        if (rem_dec <= LEN_W'(1)) begin
          push_data.has_tail = 1'b1;
          rem_nxt            = '0;
        end else begin
          rem_nxt = rem_dec;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bss_r     <= '0;
      tag_cnt_r <= '0;
      rem_r     <= '0;
    end else begin
      if (cfg_we) begin
        bss_r <= cfg_wdata;
      end
      tag_cnt_r <= tag_cnt_nxt;
      rem_r     <= rem_nxt;
    end
  end

  always_ff @(posedge clk) begin
    held_r     <= held_nxt;
    pkt_link_r <= pkt_link_nxt;
    pkt_tag_r  <= pkt_tag_nxt;
  end

endmodule

FILE: src/mrfb_queue.sv
`timescale 1ns / 1ps
module mrfb_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push_valid,
  output logic             push_ready,
  input  logic [WIDTH-1:0] push_data,
  output logic             pop_valid,
  input  logic             pop_ready,
  output logic [WIDTH-1:0] pop_data
);
  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_push, do_pop;

  assign push_ready = (count_r != CNT_W'(DEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_data   = mem_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

FILE: src/mrfb_back.sv
`timescale 1ns / 1ps
module mrfb_back #(
  parameter int TAG_BITS = 11
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         head_valid,
  output logic                         head_pop,
  input  mrfb_pkg::flit_entry_t        head,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [mrfb_pkg::DATA_W-1:0]  out_flit_low,
  output logic [mrfb_pkg::DATA_W-1:0]  out_flit_high,
  output logic [mrfb_pkg::LINK_W-1:0]  out_link,
  output logic                         out_last,
  output logic [TAG_BITS-1:0]          out_tag
);
  import mrfb_pkg::*;

  logic                out_valid_r, out_valid_nxt;
  logic                tail_pending_r, tail_pending_nxt;
  logic [DATA_W-1:0]   lo_r, lo_nxt;
  logic [DATA_W-1:0]   hi_r, hi_nxt;
  logic [LINK_W-1:0]   link_r, link_nxt;
  logic                last_r, last_nxt;
  logic [TAG_BITS-1:0] tag_r, tag_nxt;
  logic                load;

  assign load = head_valid && (!out_valid_r || out_ready);

  always_comb begin
    out_valid_nxt    = out_valid_r;
    tail_pending_nxt = tail_pending_r;
    lo_nxt           = lo_r;
    hi_nxt           = hi_r;
    link_nxt         = link_r;
    last_nxt         = last_r;
    tag_nxt          = tag_r;
    head_pop         = 1'b0;
    if (load) begin
      out_valid_nxt = 1'b1;
      link_nxt      = head.link;
      tag_nxt       = head.tag[TAG_BITS-1:0];
      if (!tail_pending_r) begin
        lo_nxt   = head.lo0;
        hi_nxt   = head.hi0;
        last_nxt = head.last0;
        if (head.has_tail) begin
          tail_pending_nxt = 1'b1;
        end else begin
          head_pop = 1'b1;
        end
      end else begin
        // second flit of the entry: held half below, tail above
        lo_nxt           = head.tail_lo;
        hi_nxt           = make_tail(head.link);
        last_nxt         = 1'b1;
        tail_pending_nxt = 1'b0;
        head_pop         = 1'b1;
      end
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r    <= 1'b0;
      tail_pending_r <= 1'b0;
    end else begin
      out_valid_r    <= out_valid_nxt;
      tail_pending_r <= tail_pending_nxt;
    end
  end

  always_ff @(posedge clk) begin
    lo_r   <= lo_nxt;
    hi_r   <= hi_nxt;
    link_r <= link_nxt;
    last_r <= last_nxt;
    tag_r  <= tag_nxt;
  end

  assign out_valid     = out_valid_r;
  assign out_flit_low  = lo_r;
  assign out_flit_high = hi_r;
  assign out_link      = link_r;
  assign out_last      = last_r;
  assign out_tag       = tag_r;

endmodule

FILE: src/mrfb_checker.sv
`timescale 1ns / 1ps
module mrfb_checker #(
  parameter int TAG_BITS = 11
) (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         in_ready,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic [mrfb_pkg::DATA_W-1:0]  out_flit_low,
  input logic [mrfb_pkg::DATA_W-1:0]  out_flit_high,
  input logic [mrfb_pkg::LINK_W-1:0]  out_link,
  input logic                         out_last,
  input logic [TAG_BITS-1:0]          out_tag
);
  import mrfb_pkg::*;

  // stalled flit beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_flit_low) &&
      $stable(out_flit_high) && $stable(out_link) && $stable(out_last) &&
      $stable(out_tag))
    else $error("flit beat changed while stalled");

  // last flit carries a well-formed tail for its own link
  a_tail_format: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last |-> out_flit_high[TAIL_RSVD_LSB-1:0] == '0 &&
      out_flit_high[TAIL_RSVD_LSB +: 4] == TAIL_RSVD &&
      out_flit_high[TAIL_LINK_LSB +: LINK_W] == out_link &&
      out_flit_high[DATA_W-1:TAIL_LINK_LSB+LINK_W] == '0)
    else $error("malformed tail");

  // reset leaves nothing on the output
  a_reset_out: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("flit beat shown right after reset");

  // reset leaves the queue empty, so input is open
  a_reset_in: assert property (@(posedge clk)
    !rst_n |=> in_ready)
    else $error("input not ready after reset");

endmodule

bind memory_request_flit_builder mrfb_checker #(.TAG_BITS(TAG_BITS)) u_mrfb_checker (.*);

FILE: verif/tb_memory_request_flit_builder.sv
`timescale 1ns / 1ps
module tb_memory_request_flit_builder;
  import mrfb_pkg::*;

  localparam int TAG_BITS       = 11;
  localparam int MAX_FLITS      = 17;
  // cycles with no beat on either channel before the run is called hung
  localparam int WATCHDOG_LIMIT = 1000;
  // quiet cycles after the last flit: covers beats still inside that give no flit
  localparam int SETTLE_CYCLES  = 16;
  // length of the one long receiver hold-off, long enough to back up the input
  localparam int LONG_HOLD      = 80;
  localparam int PHASE_BEATS    = 150;
  localparam int RANDOM_PHASES  = 6;

  // one input beat as the sender offers it
  typedef struct packed {
    op_t               op;
    logic [CMD_W-1:0]  cmd;
    logic [ADDR_W-1:0] addr;
    logic [CUBE_W-1:0] cube;
    logic [DATA_W-1:0] dlo;
    logic [DATA_W-1:0] dhi;
  } beat_t;

  // one flit as the receiver should see it
  typedef struct packed {
    logic [DATA_W-1:0]   lo;
    logic [DATA_W-1:0]   hi;
    logic [LINK_W-1:0]   link;
    logic                last;
    logic [TAG_BITS-1:0] tag;
  } flit_t;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  logic                cfg_we    = 1'b0;
  logic [BSS_W-1:0]    cfg_wdata = '0;

  logic                in_valid     = 1'b0;
  logic                in_ready;
  logic                in_operation = 1'b0;
  logic [CMD_W-1:0]    in_command   = '0;
  logic [ADDR_W-1:0]   in_address   = '0;
  logic [CUBE_W-1:0]   in_cube_id   = '0;
  logic [DATA_W-1:0]   in_data_low  = '0;
  logic [DATA_W-1:0]   in_data_high = '0;

  logic                out_valid;
  logic                out_ready = 1'b0;
  logic [DATA_W-1:0]   out_flit_low;
  logic [DATA_W-1:0]   out_flit_high;
  logic [LINK_W-1:0]   out_link;
  logic                out_last;
  logic [TAG_BITS-1:0] out_tag;

  memory_request_flit_builder #(
    .TAG_BITS  (TAG_BITS),
    .MAX_FLITS (MAX_FLITS)
  ) DUT (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_operation  (in_operation),
    .in_command    (in_command),
    .in_address    (in_address),
    .in_cube_id    (in_cube_id),
    .in_data_low   (in_data_low),
    .in_data_high  (in_data_high),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_flit_low  (out_flit_low),
    .out_flit_high (out_flit_high),
    .out_link      (out_link),
    .out_last      (out_last),
    .out_tag       (out_tag)
  );

  // 8 ns period
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // beats waiting to go out, and flits the framer should produce, oldest first
  beat_t pending_beats[$];
  flit_t expected_flits[$];

  // framer state as the checker tracks it; all zero out of reset
  logic [BSS_W-1:0]    blk_sel    = '0;
  logic [TAG_BITS-1:0] tag_next   = '0;
  logic [DATA_W-1:0]   held_hi    = '0;
  logic [LEN_W-1:0]    flits_left = '0;
  logic [LINK_W-1:0]   pkt_link   = '0;
  logic [TAG_BITS-1:0] pkt_tag    = '0;

  // sender and receiver control
  beat_t cur_beat;
  flit_t exp_f;
  int    gap_left       = 0;
  int    stall_left     = 0;
  int    hold_left      = 0;
  bit    idle_en        = 1'b1;
  bit    long_hold_req  = 1'b0;
  bit    long_hold_done = 1'b0;
  int    err_count      = 0;
  int    quiet_cycles   = 0;

  // ---------------------------------------------------------------------------
  // flit count per command; unknown codes give zero
  // ---------------------------------------------------------------------------
  function automatic logic [LEN_W-1:0] flits_for_cmd(input logic [CMD_W-1:0] c);
    logic [LEN_W-1:0] n;
    n = '0;
    if (c >= CMD_WR16 && c <= CMD_WR128) n = LEN_W'(c - CMD_WR16 + 2);
    else if (c >= CMD_P_WR16 && c <= CMD_P_WR128) n = LEN_W'(c - CMD_P_WR16 + 2);
    else if (c >= CMD_RD16 && c <= CMD_RD128) n = LEN_W'(1);
    else if ((c >= CMD_BOOL_FIRST && c <= CMD_BOOL_LAST) ||
             (c >= CMD_CAS_FIRST && c <= CMD_CAS_LAST)) n = LEN_W'(2);
    else case (c)
      CMD_WR256, CMD_P_WR256:                        n = LEN_W'(17);
      CMD_RD256, CMD_MD_RD, CMD_INC8, CMD_P_INC8:    n = LEN_W'(1);
      CMD_MD_WR, CMD_BWR, CMD_TWO_ADD8, CMD_ADD16,
      CMD_P_BWR, CMD_P_TWO_ADD8, CMD_P_ADD16,
      CMD_BWR8R, CMD_TWO_ADDS8R, CMD_ADDS16R,
      CMD_CASEQ8, CMD_CASZERO16, CMD_EQ16, CMD_EQ8,
      CMD_SWAP16:                                    n = LEN_W'(2);
      default:                                       n = '0;
    endcase
    // lengths above the framer's limit count as unknown
    if (n > MAX_FLITS) n = '0;
    return n;
  endfunction

  // tail word: reserved ones at [25:22], link at [27:26]
  function automatic logic [DATA_W-1:0] tail_word(input logic [LINK_W-1:0] l);
    return {36'd0, l, TAIL_RSVD, 22'd0};
  endfunction

  task automatic emit_flit(input logic [DATA_W-1:0] lo, input logic [DATA_W-1:0] hi,
                           input logic is_last);
    expected_flits.push_back('{lo: lo, hi: hi, link: pkt_link, last: is_last,
                               tag: pkt_tag});
  endtask

  // ---------------------------------------------------------------------------
  // flit predictor: advances the tracked state by one accepted beat
  // ---------------------------------------------------------------------------
  task automatic predict_flits(input beat_t b);
    logic [LEN_W-1:0]  n;
    logic [DATA_W-1:0] hdr;
    if (b.op == OP_REQUEST) begin
      n = flits_for_cmd(b.cmd);
      // a new request always drops whatever packet was open
      flits_left = '0;
      if (n != '0) begin
        pkt_link = LINK_W'(b.addr >> (LINK_ADDR_BASE + blk_sel));
        pkt_tag  = tag_next;
        tag_next = tag_next + 1'b1;
        // cube | rsvd 111 | address | 0 | tag | length | command
        hdr = {b.cube, HDR_RSVD, b.addr, 1'b0, pkt_tag, n, b.cmd};
        if (n == LEN_W'(1)) begin
          emit_flit(hdr, tail_word(pkt_link), 1'b1);
        end else begin
          emit_flit(hdr, b.dlo, 1'b0);
          held_hi = b.dhi;
          if (n == LEN_W'(2)) emit_flit(held_hi, tail_word(pkt_link), 1'b1);
          else flits_left = n - 1'b1;
        end
      end
    end else if (flits_left != '0) begin
      // previous high half joins this beat's low half
      emit_flit(held_hi, b.dlo, 1'b0);
      held_hi    = b.dhi;
      flits_left = flits_left - 1'b1;
      if (flits_left <= LEN_W'(1)) begin
        emit_flit(held_hi, tail_word(pkt_link), 1'b1);
        flits_left = '0;
      end
    end
    // data beat with no open packet: dropped, nothing expected
  endtask

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------
  function automatic beat_t mk_beat(input op_t op, input logic [CMD_W-1:0] c,
                                    input logic [ADDR_W-1:0] a,
                                    input logic [CUBE_W-1:0] cu,
                                    input logic [DATA_W-1:0] lo,
                                    input logic [DATA_W-1:0] hi);
    return '{op: op, cmd: c, addr: a, cube: cu, dlo: lo, dhi: hi};
  endfunction

  // random fields, now and then pinned to an extreme
  function automatic beat_t rand_beat(input op_t op, input logic [CMD_W-1:0] c);
    logic [ADDR_W-1:0] a;
    logic [DATA_W-1:0] lo;
    logic [DATA_W-1:0] hi;
    a  = ADDR_W'({$urandom, $urandom});
    lo = {$urandom, $urandom};
    hi = {$urandom, $urandom};
    case ($urandom_range(0, 15))
      0: a  = '0;
      1: a  = '1;
      2: lo = '0;
      3: hi = '1;
      4: begin
        lo = '1;
        hi = '0;
      end
      default: ;
    endcase
    return mk_beat(op, c, a, CUBE_W'($urandom), lo, hi);
  endfunction

  // one random packet, mostly well formed; counted leaves out stray data beats
  task automatic queue_random_packet(output int unsigned counted);
    int unsigned pick;
    int          beats;
    logic [CMD_W-1:0] c;
    pick    = $urandom_range(0, 99);
    beats   = 0;
    counted = 0;
    c       = '0;
    if (pick >= 93) begin
      // stray data beats
      repeat ($urandom_range(1, 3))
        pending_beats.push_back(rand_beat(OP_DATA, CMD_W'($urandom)));
    end else begin
      if (pick < 30) begin
        // single-flit reads
        case ($urandom_range(0, 4))
          0:       c = CMD_RD16 + CMD_W'($urandom_range(0, 7));
          1:       c = CMD_RD256;
          2:       c = CMD_MD_RD;
          3:       c = CMD_INC8;
          default: c = CMD_P_INC8;
        endcase
      end else if (pick < 50) begin
        // two-flit atomics
        case ($urandom_range(0, 16))
          0:       c = CMD_MD_WR;
          1:       c = CMD_BWR;
          2:       c = CMD_TWO_ADD8;
          3:       c = CMD_ADD16;
          4:       c = CMD_P_BWR;
          5:       c = CMD_P_TWO_ADD8;
          6:       c = CMD_P_ADD16;
          7:       c = CMD_BWR8R;
          8:       c = CMD_TWO_ADDS8R;
          9:       c = CMD_ADDS16R;
          10:      c = CMD_CASEQ8;
          11:      c = CMD_CASZERO16;
          12:      c = CMD_EQ16;
          13:      c = CMD_EQ8;
          14:      c = CMD_SWAP16;
          15:      c = CMD_BOOL_FIRST + CMD_W'($urandom_range(0, 4));
          default: c = CMD_CAS_FIRST + CMD_W'($urandom_range(0, 3));
        endcase
      end else if (pick < 75) begin
        // writes of 2 to 9 flits, complete
        c = (($urandom_range(0, 1) == 1) ? CMD_P_WR16 : CMD_WR16) +
            CMD_W'($urandom_range(0, 7));
        beats = int'(flits_for_cmd(c)) - 2;
      end else if (pick < 82) begin
        // full-size writes, complete
        c = ($urandom_range(0, 1) == 1) ? CMD_P_WR256 : CMD_WR256;
        beats = int'(flits_for_cmd(c)) - 2;
      end else if (pick < 88) begin
        // long write cut short; the next request abandons it
        c = ($urandom_range(0, 3) == 0) ? CMD_WR256 :
            (CMD_WR16 + CMD_W'($urandom_range(1, 7)));
        beats = $urandom_range(0, int'(flits_for_cmd(c)) - 3);
      end else begin
        // unknown command
        do c = CMD_W'($urandom); while (flits_for_cmd(c) != '0);
      end
      pending_beats.push_back(rand_beat(OP_REQUEST, c));
      repeat (beats) pending_beats.push_back(rand_beat(OP_DATA, CMD_W'($urandom)));
      counted = 1 + beats;
    end
  endtask

  task automatic report_mismatch(input string what, input logic [DATA_W-1:0] got,
                                 input logic [DATA_W-1:0] want);
    if (err_count < 200)
      $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
    err_count++;
  endtask

  // block size select, written only while nothing is in flight
  task automatic set_block_size(input logic [BSS_W-1:0] v);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we    <= 1'b0;
    blk_sel    = v;
  endtask

  // sender pause: every beat taken, every flit seen, then let dropped beats clear
  task automatic wait_drained();
    do @(negedge clk);
    while (pending_beats.size() != 0 || in_valid || expected_flits.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // driver: offers pending beats, with random gaps between them
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      gap_left  = 0;
    end else begin
      // beat taken at this edge
      if (in_valid && in_ready) predict_flits(cur_beat);
      // valid holds until taken, so only touch the payload once the slot is free
      if (!in_valid || in_ready) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (idle_en && pending_beats.size() != 0 &&
                     $urandom_range(0, 7) == 0) begin
          gap_left = $urandom_range(1, 8) - 1;
          in_valid <= 1'b0;
        end else if (pending_beats.size() != 0) begin
          cur_beat = pending_beats.pop_front();
          in_valid     <= 1'b1;
          in_operation <= cur_beat.op;
          in_command   <= cur_beat.cmd;
          in_address   <= cur_beat.addr;
          in_cube_id   <= cur_beat.cube;
          in_data_low  <= cur_beat.dlo;
          in_data_high <= cur_beat.dhi;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // monitor: checks each flit beat against the oldest prediction, drives ready
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
      stall_left = 0;
      hold_left  = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_flits.size() == 0) begin
          report_mismatch("flit with none predicted, low half", out_flit_low, '0);
        end else begin
          exp_f = expected_flits.pop_front();
          if (out_flit_low !== exp_f.lo) report_mismatch("flit_low", out_flit_low, exp_f.lo);
          if (out_flit_high !== exp_f.hi)
            report_mismatch("flit_high", out_flit_high, exp_f.hi);
          if (out_link !== exp_f.link)
            report_mismatch("link", DATA_W'(out_link), DATA_W'(exp_f.link));
          if (out_last !== exp_f.last)
            report_mismatch("last", DATA_W'(out_last), DATA_W'(exp_f.last));
          if (out_tag !== exp_f.tag)
            report_mismatch("tag", DATA_W'(out_tag), DATA_W'(exp_f.tag));
        end
      end
      // one long hold-off so the framer backs up and stalls its input
      if (long_hold_req && !long_hold_done) begin
        long_hold_done = 1'b1;
        hold_left      = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else if (idle_en && $urandom_range(0, 9) == 0) begin
        stall_left = $urandom_range(1, 8) - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // watchdog: ends the run when no beat moves on either side for too long
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no beat moved for %0d cycles", WATCHDOG_LIMIT);
      $display("CHECKS FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // test sequence: directed phase, then random phases over all block sizes
  // ---------------------------------------------------------------------------
  initial begin
    int unsigned n;
    int unsigned k;
    logic [BSS_W-1:0] sel;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // directed: smallest block size, field extremes and every special case
    set_block_size(2'd0);
    @(negedge clk);
    // single-flit read at the top of the address space
    pending_beats.push_back(mk_beat(OP_REQUEST, CMD_RD16, '1, 3'd7, '1, '1));
    // two-flit atomic at address zero
    pending_beats.push_back(mk_beat(OP_REQUEST, CMD_MD_WR, '0, 3'd0, '1, '1));
    // shortest write, zero data
    pending_beats.push_back(mk_beat(OP_REQUEST, CMD_WR16, 34'h2_AAAA_AAAA, 3'd5, '0, '0));
    // three-flit write: request plus one data beat
    pending_beats.push_back(mk_beat(OP_REQUEST, CMD_P_WR16 + 7'd1, 34'h1_5555_5555, 3'd2,
                                    64'h0123_4567_89AB_CDEF, 64'hFEDC_BA98_7654_3210));
    pending_beats.push_back(mk_beat(OP_DATA, '1, '1, 3'd7, '1, '0));
    // stray data beat, no packet open
    pending_beats.push_back(mk_beat(OP_DATA, '0, '0, 3'd0, '0, '1));
    // unknown commands at both ends of the code space
    pending_beats.push_back(mk_beat(OP_REQUEST, 7'h00, '1, 3'd7, '1, '1));
    pending_beats.push_back(mk_beat(OP_REQUEST, 7'h7F, '0, 3'd0, '0, '0));
    // nine-flit write cut short by a new read
    pending_beats.push_back(mk_beat(OP_REQUEST, CMD_WR128, 34'h0_0000_0300, 3'd1, '1, '0));
    pending_beats.push_back(mk_beat(OP_DATA, '0, '0, 3'd0, 64'h1111, 64'h2222));
    pending_beats.push_back(mk_beat(OP_DATA, '0, '0, 3'd0, 64'h3333, 64'h4444));
    pending_beats.push_back(mk_beat(OP_REQUEST, CMD_RD256, 34'h0_0000_0100, 3'd3, '0, '0));
    // open write abandoned by an unknown command, then a data beat that is dropped
    pending_beats.push_back(mk_beat(OP_REQUEST, CMD_WR16 + 7'd2, 34'h0_0000_0200, 3'd4,
                                    64'h5, 64'h6));
    pending_beats.push_back(mk_beat(OP_REQUEST, 7'h01, '0, 3'd0, '0, '0));
    pending_beats.push_back(mk_beat(OP_DATA, '0, '0, 3'd0, 64'h7, 64'h8));
    // remaining command groups
    pending_beats.push_back(mk_beat(OP_REQUEST, CMD_INC8, 34'h3_0000_0000, 3'd6, '0, '0));
    pending_beats.push_back(mk_beat(OP_REQUEST, CMD_SWAP16, 34'h0_0000_0080, 3'd0, '1, '0));
    pending_beats.push_back(mk_beat(OP_REQUEST, CMD_BOOL_LAST, '1, 3'd1, '0, '1));
    pending_beats.push_back(mk_beat(OP_REQUEST, CMD_CAS_FIRST, '0, 3'd2, '1, '1));
    pending_beats.push_back(mk_beat(OP_REQUEST, CMD_P_INC8, 34'h0_0000_0F00, 3'd3, '0, '0));
    wait_drained();

    // random phases; each boundary is a full sender pause
    for (int phase = 1; phase <= RANDOM_PHASES; phase++) begin
      case (phase)
        1:       sel = 2'd3;
        2:       sel = 2'd0;
        3:       sel = 2'd2;
        4:       sel = 2'd1;
        5:       sel = BSS_W'($urandom_range(0, 3));
        default: sel = 2'd3;
      endcase
      set_block_size(sel);
      @(negedge clk);
      // last phase runs back to back on both sides
      if (phase == RANDOM_PHASES) idle_en = 1'b0;
      n = 0;
      while (n < PHASE_BEATS) begin
        queue_random_packet(k);
        n += k;
      end
      if (phase == 2) long_hold_req = 1'b1;
      wait_drained();
    end

    if (err_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
